// ===== sv/window_size_constrainer_top_macros.svh =====
// Assertion macros for the window size constrainer.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef WINDOW_SIZE_CONSTRAINER_TOP_MACROS_SVH
`define WINDOW_SIZE_CONSTRAINER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsc assertion failed");

// Next-cycle implication, disabled during reset.
`define WSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsc assertion failed");

`endif

// ===== sv/wsc_pkg.sv =====
// Shared types, constants and helper functions for the window size constrainer.
// No dependencies.
package wsc_pkg;

    localparam int COORD_BITS = 16;
    localparam int VAL_W      = (COORD_BITS > 32 ? COORD_BITS : 32) + 1;
    localparam int HALF_W     = 16;
    localparam int CFG_W      = 31;
    localparam int DIV_NUM_W  = 32;
    localparam int DIV_DEN_W  = 16;
    localparam int PROD_W     = VAL_W + HALF_W + 1;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic [CFG_W-1:0] MIN_SIZE_RST   = 31'h0001_0001;
    localparam logic [CFG_W-1:0] MAX_SIZE_RST   = 31'h7FFF_7FFF;
    localparam logic [CFG_W-1:0] BASE_SIZE_RST  = 31'h0000_0000;
    localparam logic [CFG_W-1:0] SIZE_STEP_RST  = 31'h0001_0001;
    localparam logic [CFG_W-1:0] RATIO_LO_RST   = 31'h0001_0001;
    localparam logic [CFG_W-1:0] RATIO_HI_RST   = 31'h0001_0001;

    typedef enum logic [2:0] {
        REG_MIN_SIZE,
        REG_MAX_SIZE,
        REG_BASE_SIZE,
        REG_SIZE_STEP,
        REG_RATIO_LO,
        REG_RATIO_HI,
        REG_ASPECT_ON,
        REG_LIMIT_ON
    } reg_idx_t;

    typedef logic [HALF_W-1:0]            half_t;
    typedef logic signed [VAL_W-1:0]      val_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Per-item data that travels down the pipeline.
    typedef struct packed {
        val_t   w;
        val_t   h;
        coord_t lw;
        coord_t lh;
        logic   keep_x;
        logic   round_up;
        logic   act;
    } ctx_t;

    // Decoded configuration; steps already forced to at least 1.
    typedef struct packed {
        half_t min_w;
        half_t min_h;
        half_t max_w;
        half_t max_h;
        half_t base_w;
        half_t base_h;
        half_t step_w;
        half_t step_h;
        half_t min_ax;
        half_t min_ay;
        half_t max_ax;
        half_t max_ay;
        logic  aspect_on;
        logic  limit_on;
    } cfg_t;

    function automatic val_t zext_half(input half_t v);
        return {{(VAL_W-HALF_W){1'b0}}, v};
    endfunction

    function automatic val_t zext_quo(input logic [DIV_NUM_W-1:0] v);
        return {{(VAL_W-DIV_NUM_W){1'b0}}, v};
    endfunction

    // min(v, hi) then max(that, lo): the minimum wins when lo > hi.
    function automatic val_t clamp_val(input val_t v, input half_t lo, input half_t hi);
        val_t lo_v;
        val_t hi_v;
        val_t r;
        lo_v = zext_half(lo);
        hi_v = zext_half(hi);
        r    = v;
        if (r > hi_v)
        begin
            r = hi_v;
        end
        if (r < lo_v)
        begin
            r = lo_v;
        end
        return r;
    endfunction

endpackage

// ===== sv/wsc_if.sv =====
// Request and result channel interfaces for the window size constrainer.
// Depends on wsc_pkg.
interface wsc_req_if;
    logic                                valid;
    logic                                ready;
    logic signed [wsc_pkg::COORD_BITS-1:0] req_width;
    logic signed [wsc_pkg::COORD_BITS-1:0] req_height;
    logic                                keep_x;
    logic                                round_up;
    logic signed [wsc_pkg::COORD_BITS-1:0] limit_width;
    logic signed [wsc_pkg::COORD_BITS-1:0] limit_height;

    modport source (output valid, req_width, req_height, keep_x, round_up,
                    limit_width, limit_height, input ready);
    modport sink   (input valid, req_width, req_height, keep_x, round_up,
                    limit_width, limit_height, output ready);
endinterface

interface wsc_res_if;
    logic                          valid;
    logic                          ready;
    logic [wsc_pkg::COORD_BITS-1:0] fitted_width;
    logic [wsc_pkg::COORD_BITS-1:0] fitted_height;

    modport source (output valid, fitted_width, fitted_height, input ready);
    modport sink   (input valid, fitted_width, fitted_height, output ready);
endinterface

// ===== sv/wsc_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with item context.
// Depends on wsc_pkg.
module wsc_div_pipe (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [wsc_pkg::DIV_NUM_W-1:0]    in_num,
    input  logic [wsc_pkg::DIV_DEN_W-1:0]    in_den,
    input  wsc_pkg::ctx_t                    in_ctx,
    output logic                             out_valid,
    output logic [wsc_pkg::DIV_NUM_W-1:0]    out_quo,
    output logic [wsc_pkg::DIV_DEN_W-1:0]    out_rem,
    output wsc_pkg::ctx_t                    out_ctx
);
    localparam int N = wsc_pkg::DIV_NUM_W;
    localparam int D = wsc_pkg::DIV_DEN_W;

    logic [N-1:0]  vld_reg;
    logic [N-1:0]  num_reg [N];
    logic [D-1:0]  rem_reg [N];
    logic [D-1:0]  den_reg [N];
    wsc_pkg::ctx_t ctx_reg [N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic          vld_i;
            logic [N-1:0]  num_i;
            logic [D-1:0]  rem_i;
            logic [D-1:0]  den_i;
            wsc_pkg::ctx_t ctx_i;
            logic [D:0]    trial;
            logic          take;

            if (k == 0)
            begin : g_first
                assign vld_i = in_valid;
                assign num_i = in_num;
                assign rem_i = '0;
                assign den_i = in_den;
                assign ctx_i = in_ctx;
            end
            else
            begin : g_next
                assign vld_i = vld_reg[k-1];
                assign num_i = num_reg[k-1];
                assign rem_i = rem_reg[k-1];
                assign den_i = den_reg[k-1];
                assign ctx_i = ctx_reg[k-1];
            end

            // numerator shifts out at the top, quotient bits shift in below
            assign trial = {rem_i, num_i[N-1]};
            assign take  = (trial >= {1'b0, den_i});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_i;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[k] <= {num_i[N-2:0], take};
                    rem_reg[k] <= take ? D'(trial - {1'b0, den_i}) : trial[D-1:0];
                    den_reg[k] <= den_i;
                    ctx_reg[k] <= ctx_i;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[N-1];
    assign out_quo   = num_reg[N-1];
    assign out_rem   = rem_reg[N-1];
    assign out_ctx   = ctx_reg[N-1];

endmodule

// ===== sv/wsc_ratio_fix.sv =====
// One aspect ratio check and repair: compare, clamp, derive, clamp, derive.
// Depends on wsc_pkg and wsc_div_pipe.
module wsc_ratio_fix (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          sel_max,
    input  wsc_pkg::cfg_t cfg,
    input  logic          in_valid,
    input  wsc_pkg::ctx_t in_ctx,
    output logic          out_valid,
    output wsc_pkg::ctx_t out_ctx
);
    localparam int PW = wsc_pkg::PROD_W;
    localparam int HW = wsc_pkg::HALF_W;
    localparam int NW = wsc_pkg::DIV_NUM_W;
    localparam int DW = wsc_pkg::DIV_DEN_W;

    wsc_pkg::half_t x;
    wsc_pkg::half_t y;

    assign x = sel_max ? cfg.max_ax : cfg.min_ax;
    assign y = sel_max ? cfg.max_ay : cfg.min_ay;

    // stage 1: cross products
    logic                 s1_valid_reg;
    wsc_pkg::ctx_t        s1_ctx_reg;
    logic signed [PW-1:0] s1_pl_reg;
    logic signed [PW-1:0] s1_pr_reg;
    logic signed [PW-1:0] s1_pl_next;
    logic signed [PW-1:0] s1_pr_next;

    always_comb
    begin
        s1_pl_next = $signed({1'b0, x}) * in_ctx.h;
        s1_pr_next = $signed({1'b0, y}) * in_ctx.w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctx_reg <= in_ctx;
            s1_pl_reg  <= s1_pl_next;
            s1_pr_reg  <= s1_pr_next;
        end
    end

    // stage 2: decide, clamp the driving dimension
    logic           s2_valid_reg;
    wsc_pkg::ctx_t  s2_ctx_reg;
    wsc_pkg::ctx_t  s2_ctx_next;
    wsc_pkg::half_t s2_a_reg;
    wsc_pkg::half_t s2_a_next;
    wsc_pkg::val_t  s2_a_full;
    logic           s2_viol;

    always_comb
    begin
        s2_viol = sel_max ? (s1_pl_reg < s1_pr_reg) : (s1_pl_reg > s1_pr_reg);
        s2_ctx_next     = s1_ctx_reg;
        s2_ctx_next.act = cfg.aspect_on && (x != '0) && (y != '0) && s2_viol;
        if (s1_ctx_reg.keep_x)
        begin
            s2_a_full = wsc_pkg::clamp_val(s1_ctx_reg.w, cfg.min_w, cfg.max_w);
        end
        else
        begin
            s2_a_full = wsc_pkg::clamp_val(s1_ctx_reg.h, cfg.min_h, cfg.max_h);
        end
        s2_a_next = s2_a_full[HW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ctx_reg <= s2_ctx_next;
            s2_a_reg   <= s2_a_next;
        end
    end

    // stage 3: first dividend
    logic          s3_valid_reg;
    wsc_pkg::ctx_t s3_ctx_reg;
    logic [NW-1:0] s3_num_reg;
    logic [NW-1:0] s3_num_next;
    logic [DW-1:0] s3_den_reg;
    logic [DW-1:0] s3_den_next;

    always_comb
    begin
        s3_num_next = NW'(s2_a_reg) * NW'(s2_ctx_reg.keep_x ? y : x);
        s3_den_next = s2_ctx_reg.keep_x ? x : y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_ctx_reg <= s2_ctx_reg;
            s3_num_reg <= s3_num_next;
            s3_den_reg <= s3_den_next;
        end
    end

    logic          d1_valid;
    logic [NW-1:0] d1_quo;
    wsc_pkg::ctx_t d1_ctx;

    wsc_div_pipe u_div_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_num    (s3_num_reg),
        .in_den    (s3_den_reg),
        .in_ctx    (s3_ctx_reg),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_rem   (),
        .out_ctx   (d1_ctx)
    );

    // stage 4: clamp the derived dimension
    logic          s4_valid_reg;
    wsc_pkg::ctx_t s4_ctx_reg;
    wsc_pkg::ctx_t s4_ctx_next;
    wsc_pkg::val_t s4_b;

    always_comb
    begin
        s4_ctx_next = d1_ctx;
        if (d1_ctx.keep_x)
        begin
            s4_b = wsc_pkg::clamp_val(wsc_pkg::zext_quo(d1_quo), cfg.min_h, cfg.max_h);
            if (d1_ctx.act)
            begin
                s4_ctx_next.h = s4_b;
            end
        end
        else
        begin
            s4_b = wsc_pkg::clamp_val(wsc_pkg::zext_quo(d1_quo), cfg.min_w, cfg.max_w);
            if (d1_ctx.act)
            begin
                s4_ctx_next.w = s4_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_ctx_reg <= s4_ctx_next;
        end
    end

    // stage 5: second dividend
    logic           s5_valid_reg;
    wsc_pkg::ctx_t  s5_ctx_reg;
    logic [NW-1:0]  s5_num_reg;
    logic [NW-1:0]  s5_num_next;
    logic [DW-1:0]  s5_den_reg;
    logic [DW-1:0]  s5_den_next;
    wsc_pkg::val_t  s5_m;
    wsc_pkg::half_t s5_mh;

    always_comb
    begin
        s5_m        = s4_ctx_reg.keep_x ? s4_ctx_reg.h : s4_ctx_reg.w;
        s5_mh       = s5_m[HW-1:0];
        s5_num_next = NW'(s5_mh) * NW'(s4_ctx_reg.keep_x ? x : y);
        s5_den_next = s4_ctx_reg.keep_x ? y : x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_ctx_reg <= s4_ctx_reg;
            s5_num_reg <= s5_num_next;
            s5_den_reg <= s5_den_next;
        end
    end

    logic          d2_valid;
    logic [NW-1:0] d2_quo;
    wsc_pkg::ctx_t d2_ctx;

    wsc_div_pipe u_div_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_valid_reg),
        .in_num    (s5_num_reg),
        .in_den    (s5_den_reg),
        .in_ctx    (s5_ctx_reg),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_rem   (),
        .out_ctx   (d2_ctx)
    );

    // stage 6: place the second derived value
    logic          s6_valid_reg;
    wsc_pkg::ctx_t s6_ctx_reg;
    wsc_pkg::ctx_t s6_ctx_next;

    always_comb
    begin
        s6_ctx_next = d2_ctx;
        if (d2_ctx.act)
        begin
            if (d2_ctx.keep_x)
            begin
                s6_ctx_next.w = wsc_pkg::zext_quo(d2_quo);
            end
            else
            begin
                s6_ctx_next.h = wsc_pkg::zext_quo(d2_quo);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_ctx_reg <= s6_ctx_next;
        end
    end

    assign out_valid = s6_valid_reg;
    assign out_ctx   = s6_ctx_reg;

endmodule

// ===== sv/wsc_snap.sv =====
// Size range clamp, external limit, step snapping and final floor/saturation.
// Depends on wsc_pkg and wsc_div_pipe.
module wsc_snap (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  wsc_pkg::cfg_t                   cfg,
    input  logic                            in_valid,
    input  wsc_pkg::ctx_t                   in_ctx,
    output logic                            out_valid,
    output logic [wsc_pkg::COORD_BITS-1:0]  fitted_width,
    output logic [wsc_pkg::COORD_BITS-1:0]  fitted_height
);
    localparam int CB = wsc_pkg::COORD_BITS;
    localparam int VW = wsc_pkg::VAL_W;
    localparam int NW = wsc_pkg::DIV_NUM_W;
    localparam int DW = wsc_pkg::DIV_DEN_W;

    function automatic wsc_pkg::val_t sext_coord(input wsc_pkg::coord_t v);
        return {{(VW-CB){v[CB-1]}}, v};
    endfunction

    function automatic logic [CB-1:0] finish(input wsc_pkg::val_t v);
        wsc_pkg::val_t top;
        logic [CB-1:0] r;
        top = {{(VW-CB){1'b0}}, {CB{1'b1}}};
        if (v <= 0)
        begin
            r = CB'(1);
        end
        else if (v > top)
        begin
            r = {CB{1'b1}};
        end
        else
        begin
            r = v[CB-1:0];
        end
        return r;
    endfunction

    // stage 1: range clamp and limit
    logic          t1_valid_reg;
    wsc_pkg::ctx_t t1_ctx_reg;
    wsc_pkg::ctx_t t1_ctx_next;

    always_comb
    begin
        t1_ctx_next   = in_ctx;
        t1_ctx_next.h = wsc_pkg::clamp_val(in_ctx.h, cfg.min_h, cfg.max_h);
        t1_ctx_next.w = wsc_pkg::clamp_val(in_ctx.w, cfg.min_w, cfg.max_w);
        if (cfg.limit_on)
        begin
            if (t1_ctx_next.w > sext_coord(in_ctx.lw))
            begin
                t1_ctx_next.w = sext_coord(in_ctx.lw);
            end
            if (t1_ctx_next.h > sext_coord(in_ctx.lh))
            begin
                t1_ctx_next.h = sext_coord(in_ctx.lh);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_ctx_reg <= t1_ctx_next;
        end
    end

    // stage 2: width rounding and offset from base
    logic          t2_valid_reg;
    wsc_pkg::ctx_t t2_ctx_reg;
    wsc_pkg::ctx_t t2_ctx_next;
    logic [NW-1:0] t2_num_reg;
    logic [NW-1:0] t2_num_next;
    wsc_pkg::val_t t2_d;

    always_comb
    begin
        t2_ctx_next = t1_ctx_reg;
        if (t1_ctx_reg.round_up)
        begin
            t2_ctx_next.w = t1_ctx_reg.w + wsc_pkg::zext_half(cfg.step_w >> 1);
        end
        t2_d = t2_ctx_next.w - wsc_pkg::zext_half(cfg.base_w);
        if (t2_d < 0)
        begin
            t2_d = '0;
        end
        t2_num_next = t2_d[NW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t2_valid_reg <= t1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2_ctx_reg <= t2_ctx_next;
            t2_num_reg <= t2_num_next;
        end
    end

    logic          dw_valid;
    logic [DW-1:0] dw_rem;
    wsc_pkg::ctx_t dw_ctx;

    wsc_div_pipe u_div_width (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t2_valid_reg),
        .in_num    (t2_num_reg),
        .in_den    (cfg.step_w),
        .in_ctx    (t2_ctx_reg),
        .out_valid (dw_valid),
        .out_quo   (),
        .out_rem   (dw_rem),
        .out_ctx   (dw_ctx)
    );

    // stage 3: width snapped, height rounding and offset
    logic          t3_valid_reg;
    wsc_pkg::ctx_t t3_ctx_reg;
    wsc_pkg::ctx_t t3_ctx_next;
    logic [NW-1:0] t3_num_reg;
    logic [NW-1:0] t3_num_next;
    wsc_pkg::val_t t3_d;

    always_comb
    begin
        t3_ctx_next   = dw_ctx;
        t3_ctx_next.w = dw_ctx.w - wsc_pkg::zext_half(dw_rem);
        if (dw_ctx.round_up)
        begin
            t3_ctx_next.h = dw_ctx.h + wsc_pkg::zext_half(cfg.step_h >> 1);
        end
        t3_d = t3_ctx_next.h - wsc_pkg::zext_half(cfg.base_h);
        if (t3_d < 0)
        begin
            t3_d = '0;
        end
        t3_num_next = t3_d[NW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t3_valid_reg <= dw_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t3_ctx_reg <= t3_ctx_next;
            t3_num_reg <= t3_num_next;
        end
    end

    logic          dh_valid;
    logic [DW-1:0] dh_rem;
    wsc_pkg::ctx_t dh_ctx;

    wsc_div_pipe u_div_height (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t3_valid_reg),
        .in_num    (t3_num_reg),
        .in_den    (cfg.step_h),
        .in_ctx    (t3_ctx_reg),
        .out_valid (dh_valid),
        .out_quo   (),
        .out_rem   (dh_rem),
        .out_ctx   (dh_ctx)
    );

    // stage 4: height snapped, floor at 1 and saturate; this is the output register
    logic          t4_valid_reg;
    logic [CB-1:0] t4_w_reg;
    logic [CB-1:0] t4_w_next;
    logic [CB-1:0] t4_h_reg;
    logic [CB-1:0] t4_h_next;

    always_comb
    begin
        t4_w_next = finish(dh_ctx.w);
        t4_h_next = finish(dh_ctx.h - wsc_pkg::zext_half(dh_rem));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t4_valid_reg <= dh_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t4_w_reg <= t4_w_next;
            t4_h_reg <= t4_h_next;
        end
    end

    assign out_valid     = t4_valid_reg;
    assign fitted_width  = t4_w_reg;
    assign fitted_height = t4_h_reg;

endmodule

// ===== sv/window_size_constrainer_top.sv =====
// Window size constrainer: top level with APB register file and pipeline.
// Depends on wsc_pkg, wsc_if, wsc_ratio_fix, wsc_snap and the macros header.
//
// Fits a requested window width/height to size hints: optional min/max
// aspect repair (keep_x picks the driving dimension), clamp to the min/max
// size range, optional external limit cap, optional half-step rounding,
// snap down to base + k*step, then floor at 1 and saturate to the coordinate
// range. Throughput is one item per clock while the pipeline advances. It is
// built from six 32-stage bit-serial divider pipelines (two per aspect ratio,
// one each for width and height step snapping) plus sixteen surrounding
// stages. The whole pipeline advances together: it holds only while a result
// sits in the output register and the sink is not ready, and the request side
// is ready whenever the pipeline advances. Registers live at byte address 4*i
// (min_size, max_size, base_size, size_step, lower ratio, upper ratio,
// aspect_on, limit_on); write them only while no item is in flight.
`include "window_size_constrainer_top_macros.svh"

module window_size_constrainer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    wsc_req_if.sink                       req,
    wsc_res_if.source                     res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsc_pkg::ADDR_W-1:0]    paddr,
    input  logic [wsc_pkg::DATA_W-1:0]    pwdata,
    output logic [wsc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    localparam int CW = wsc_pkg::CFG_W;
    localparam int VW = wsc_pkg::VAL_W;
    localparam int CB = wsc_pkg::COORD_BITS;

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [CW-1:0] min_size_reg;
    logic [CW-1:0] max_size_reg;
    logic [CW-1:0] base_size_reg;
    logic [CW-1:0] size_step_reg;
    logic [CW-1:0] ratio_lo_reg;
    logic [CW-1:0] ratio_hi_reg;
    logic          aspect_on_reg;
    logic          limit_on_reg;

    wsc_pkg::reg_idx_t reg_idx;
    logic              wr_en;
    logic              aspect_wr;

    assign pready    = 1'b1;
    assign reg_idx   = wsc_pkg::reg_idx_t'(paddr[wsc_pkg::ADDR_W-1:2]);
    assign wr_en     = psel && penable && pwrite && pready;
    assign aspect_wr = wr_en && (reg_idx == wsc_pkg::REG_ASPECT_ON);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_size_reg   <= wsc_pkg::MIN_SIZE_RST;
            max_size_reg   <= wsc_pkg::MAX_SIZE_RST;
            base_size_reg  <= wsc_pkg::BASE_SIZE_RST;
            size_step_reg  <= wsc_pkg::SIZE_STEP_RST;
            ratio_lo_reg   <= wsc_pkg::RATIO_LO_RST;
            ratio_hi_reg   <= wsc_pkg::RATIO_HI_RST;
            aspect_on_reg  <= 1'b0;
            limit_on_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                wsc_pkg::REG_MIN_SIZE:   min_size_reg   <= pwdata[CW-1:0];
                wsc_pkg::REG_MAX_SIZE:   max_size_reg   <= pwdata[CW-1:0];
                wsc_pkg::REG_BASE_SIZE:  base_size_reg  <= pwdata[CW-1:0];
                wsc_pkg::REG_SIZE_STEP:  size_step_reg  <= pwdata[CW-1:0];
                wsc_pkg::REG_RATIO_LO:   ratio_lo_reg   <= pwdata[CW-1:0];
                wsc_pkg::REG_RATIO_HI:   ratio_hi_reg   <= pwdata[CW-1:0];
                wsc_pkg::REG_ASPECT_ON:  aspect_on_reg  <= pwdata[0];
                wsc_pkg::REG_LIMIT_ON:   limit_on_reg   <= pwdata[0];
                default:                 aspect_on_reg  <= aspect_on_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            wsc_pkg::REG_MIN_SIZE:   prdata = {1'b0, min_size_reg};
            wsc_pkg::REG_MAX_SIZE:   prdata = {1'b0, max_size_reg};
            wsc_pkg::REG_BASE_SIZE:  prdata = {1'b0, base_size_reg};
            wsc_pkg::REG_SIZE_STEP:  prdata = {1'b0, size_step_reg};
            wsc_pkg::REG_RATIO_LO:   prdata = {1'b0, ratio_lo_reg};
            wsc_pkg::REG_RATIO_HI:   prdata = {1'b0, ratio_hi_reg};
            wsc_pkg::REG_ASPECT_ON:  prdata = {{(wsc_pkg::DATA_W-1){1'b0}}, aspect_on_reg};
            wsc_pkg::REG_LIMIT_ON:   prdata = {{(wsc_pkg::DATA_W-1){1'b0}}, limit_on_reg};
            default:                 prdata = '0;
        endcase
    end

    // Decoded fields: width in the low half, height in bits 30:16.
    // A zero step behaves as a step of 1.
    wsc_pkg::cfg_t cfg;

    always_comb
    begin
        cfg.min_w     = min_size_reg[15:0];
        cfg.min_h     = {1'b0, min_size_reg[30:16]};
        cfg.max_w     = max_size_reg[15:0];
        cfg.max_h     = {1'b0, max_size_reg[30:16]};
        cfg.base_w    = base_size_reg[15:0];
        cfg.base_h    = {1'b0, base_size_reg[30:16]};
        cfg.step_w    = (size_step_reg[15:0] == '0) ? 16'd1 : size_step_reg[15:0];
        cfg.step_h    = (size_step_reg[30:16] == '0) ? 16'd1 : {1'b0, size_step_reg[30:16]};
        cfg.min_ax    = ratio_lo_reg[15:0];
        cfg.min_ay    = {1'b0, ratio_lo_reg[30:16]};
        cfg.max_ax    = ratio_hi_reg[15:0];
        cfg.max_ay    = {1'b0, ratio_hi_reg[30:16]};
        cfg.aspect_on = aspect_on_reg;
        cfg.limit_on  = limit_on_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline
    // ------------------------------------------------------------------
    // Global advance: everything moves unless the output item is stuck.
    logic          en;
    logic          snap_valid;
    wsc_pkg::ctx_t in_ctx;

    assign en        = !snap_valid || res.ready;
    assign req.ready = en;

    always_comb
    begin
        in_ctx.w        = {{(VW-CB){req.req_width[CB-1]}}, req.req_width};
        in_ctx.h        = {{(VW-CB){req.req_height[CB-1]}}, req.req_height};
        in_ctx.lw       = req.limit_width;
        in_ctx.lh       = req.limit_height;
        in_ctx.keep_x   = req.keep_x;
        in_ctx.round_up = req.round_up;
        in_ctx.act      = 1'b0;
    end

    logic          fa_valid;
    wsc_pkg::ctx_t fa_ctx;
    logic          fb_valid;
    wsc_pkg::ctx_t fb_ctx;

    // minimum ratio first; the maximum check sees its result
    wsc_ratio_fix u_fix_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .sel_max   (1'b0),
        .cfg       (cfg),
        .in_valid  (req.valid),
        .in_ctx    (in_ctx),
        .out_valid (fa_valid),
        .out_ctx   (fa_ctx)
    );

    wsc_ratio_fix u_fix_max (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .sel_max   (1'b1),
        .cfg       (cfg),
        .in_valid  (fa_valid),
        .in_ctx    (fa_ctx),
        .out_valid (fb_valid),
        .out_ctx   (fb_ctx)
    );

    wsc_snap u_snap (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .cfg           (cfg),
        .in_valid      (fb_valid),
        .in_ctx        (fb_ctx),
        .out_valid     (snap_valid),
        .fitted_width  (res.fitted_width),
        .fitted_height (res.fitted_height)
    );

    assign res.valid = snap_valid;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `WSC_ASSERT_NOW(a_result_floor, res.valid, (|res.fitted_width) && (|res.fitted_height))
    `WSC_ASSERT_NOW(a_stall_blocks_input, res.valid && !res.ready, !req.ready)
    `WSC_ASSERT_NEXT(a_aspect_write, aspect_wr, aspect_on_reg == $past(pwdata[0]))

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for window_size_constrainer_top: random and directed
// resize requests, predicted in-bench and compared with every fitted result.
// Depends on wsc_pkg, wsc_if and the RTL top level.
module tb_top;

    typedef struct {
        wsc_pkg::coord_t w;
        wsc_pkg::coord_t h;
        logic            kx;
        logic            ru;
        wsc_pkg::coord_t lw;
        wsc_pkg::coord_t lh;
    } resize_t;

    typedef struct {
        logic [wsc_pkg::COORD_BITS-1:0] w;
        logic [wsc_pkg::COORD_BITS-1:0] h;
    } fitted_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [wsc_pkg::ADDR_W-1:0] paddr;
    logic [wsc_pkg::DATA_W-1:0] pwdata;
    logic [wsc_pkg::DATA_W-1:0] prdata;
    logic pready;

    wsc_req_if req_if ();
    wsc_res_if res_if ();

    window_size_constrainer_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .res     (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the register file, kept in step with every write.
    logic [31:0] hint_regs [8];
    resize_t     resize_q [$];   // requests waiting to be offered
    fitted_t     fitted_q [$];   // predicted sizes, oldest first
    resize_t     offered;
    int          send_gap;
    int          recv_gap;
    int          hold_cnt;
    int          hold_ask;
    int          hold_done;
    bit          idle_on;
    int          errors;

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint clamp_sz(longint v, longint lo, longint hi);
        if (v > hi)
        begin
            v = hi;
        end
        if (v < lo)
        begin
            v = lo;
        end
        return v;
    endfunction

    // Repair of one broken ratio x:y; keep_x picks which side leads.
    function automatic void repair_ratio(inout longint w, inout longint h,
                                         input longint x, input longint y,
                                         input logic kx,
                                         input longint wmin, input longint wmax,
                                         input longint hmin, input longint hmax);
        if (kx)
        begin
            w = clamp_sz(w, wmin, wmax);
            h = (w * y) / x;
            h = clamp_sz(h, hmin, hmax);
            w = (h * x) / y;
        end
        else
        begin
            h = clamp_sz(h, hmin, hmax);
            w = (h * x) / y;
            w = clamp_sz(w, wmin, wmax);
            h = (w * y) / x;
        end
    endfunction

    function automatic longint snap_to_step(longint v, longint base, longint step,
                                            logic ru);
        longint d;
        if (ru)
        begin
            v = v + step / 2;
        end
        d = v - base;
        if (d < 0)
        begin
            d = 0;
        end
        return v - (d % step);
    endfunction

    function automatic logic [wsc_pkg::COORD_BITS-1:0] floor_sat(longint v);
        if (v <= 0)
        begin
            v = 1;
        end
        if (v > 65535)
        begin
            v = 65535;
        end
        return v[wsc_pkg::COORD_BITS-1:0];
    endfunction

    function automatic longint lo_of(wsc_pkg::reg_idx_t i);
        return longint'(hint_regs[i][15:0]);
    endfunction

    function automatic longint hi_of(wsc_pkg::reg_idx_t i);
        return longint'(hint_regs[i][30:16]);
    endfunction

    function automatic fitted_t fit_size(resize_t r);
        longint w, h, wmin, hmin, wmax, hmax, wstep, hstep, xa, ya, xb, yb;
        fitted_t f;
        w = r.w;
        h = r.h;
        wmin = lo_of(wsc_pkg::REG_MIN_SIZE);
        hmin = hi_of(wsc_pkg::REG_MIN_SIZE);
        wmax = lo_of(wsc_pkg::REG_MAX_SIZE);
        hmax = hi_of(wsc_pkg::REG_MAX_SIZE);
        wstep = lo_of(wsc_pkg::REG_SIZE_STEP);
        hstep = hi_of(wsc_pkg::REG_SIZE_STEP);
        if (wstep == 0)
        begin
            wstep = 1;
        end
        if (hstep == 0)
        begin
            hstep = 1;
        end
        if (hint_regs[wsc_pkg::REG_ASPECT_ON][0])
        begin
            xa = lo_of(wsc_pkg::REG_RATIO_LO);
            ya = hi_of(wsc_pkg::REG_RATIO_LO);
            xb = lo_of(wsc_pkg::REG_RATIO_HI);
            yb = hi_of(wsc_pkg::REG_RATIO_HI);
            // zero term skips that ratio; max test sees the min repair
            if (xa != 0 && ya != 0 && xa * h > ya * w)
            begin
                repair_ratio(w, h, xa, ya, r.kx, wmin, wmax, hmin, hmax);
            end
            if (xb != 0 && yb != 0 && xb * h < yb * w)
            begin
                repair_ratio(w, h, xb, yb, r.kx, wmin, wmax, hmin, hmax);
            end
        end
        h = clamp_sz(h, hmin, hmax);
        w = clamp_sz(w, wmin, wmax);
        if (hint_regs[wsc_pkg::REG_LIMIT_ON][0])
        begin
            if (w > r.lw)
            begin
                w = r.lw;
            end
            if (h > r.lh)
            begin
                h = r.lh;
            end
        end
        w = snap_to_step(w, lo_of(wsc_pkg::REG_BASE_SIZE), wstep, r.ru);
        h = snap_to_step(h, hi_of(wsc_pkg::REG_BASE_SIZE), hstep, r.ru);
        f.w = floor_sat(w);
        f.h = floor_sat(h);
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: offers queued items, with idling on a random gap after each
    // ------------------------------------------------------------------
    function automatic int draw_gap();
        return idle_on ? $urandom_range(0, 8) : 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        resize_t nxt;
        int gap;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            gap = send_gap;
            if (req_if.valid && req_if.ready)
            begin
                fitted_q.push_back(fit_size(offered));
                gap = draw_gap();
            end
            if ((req_if.valid && !req_if.ready))
            begin
                // still waiting for acceptance, hold the item
            end
            else if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                send_gap <= gap - 1;
            end
            else if (resize_q.size() > 0)
            begin
                nxt = resize_q.pop_front();
                offered = nxt;
                req_if.valid <= 1'b1;
                req_if.req_width <= nxt.w;
                req_if.req_height <= nxt.h;
                req_if.keep_x <= nxt.kx;
                req_if.round_up <= nxt.ru;
                req_if.limit_width <= nxt.lw;
                req_if.limit_height <= nxt.lh;
                send_gap <= 0;
            end
            else
            begin
                req_if.valid <= 1'b0;
                send_gap <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each item, random stalls with idling on plus long hold-offs
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        fitted_t want;
        int gap;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            recv_gap <= 0;
            hold_cnt <= 0;
            hold_done <= 0;
        end
        else
        begin
            gap = recv_gap;
            if (res_if.valid && res_if.ready)
            begin
                if (fitted_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got w=%0d h=%0d",
                             $time, res_if.fitted_width, res_if.fitted_height);
                    errors++;
                end
                else
                begin
                    want = fitted_q.pop_front();
                    if (res_if.fitted_width !== want.w)
                    begin
                        $display("%0t: fitted_width expected %0d actual %0d",
                                 $time, want.w, res_if.fitted_width);
                        errors++;
                    end
                    if (res_if.fitted_height !== want.h)
                    begin
                        $display("%0t: fitted_height expected %0d actual %0d",
                                 $time, want.h, res_if.fitted_height);
                        errors++;
                    end
                end
                gap = draw_gap();
            end
            if (hold_ask != hold_done)
            begin
                // long hold-off: lets the pipeline fill and back up the input
                hold_done <= hold_ask;
                hold_cnt <= 600;
                res_if.ready <= 1'b0;
                recv_gap <= gap;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                res_if.ready <= 1'b0;
                recv_gap <= gap;
            end
            else if (gap > 0)
            begin
                res_if.ready <= 1'b0;
                recv_gap <= gap - 1;
            end
            else
            begin
                res_if.ready <= 1'b1;
                recv_gap <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(wsc_pkg::reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= wsc_pkg::ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == wsc_pkg::REG_ASPECT_ON || idx == wsc_pkg::REG_LIMIT_ON)
        begin
            hint_regs[idx] = value & 32'h1;
        end
        else
        begin
            hint_regs[idx] = value & 32'h7FFF_FFFF;
        end
    endtask

    // Sender waits until every queued item is offered and every predicted
    // result is back, so the pipeline is empty before any register write.
    task automatic drain();
        while (resize_q.size() > 0 || req_if.valid || fitted_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_dim(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 40));
            1: return 16'($urandom_range(0, 2000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pack_pair(logic [15:0] lo, logic [15:0] hi);
        // bit 31 random: must be dropped by the register
        return {1'($urandom), hi[14:0], lo};
    endfunction

    function automatic wsc_pkg::coord_t rand_coord();
        case ($urandom_range(0, 9))
            0: return wsc_pkg::coord_t'($urandom);
            1: return wsc_pkg::coord_t'($urandom_range(0, 16)) - 16'sd8;
            2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return wsc_pkg::coord_t'($urandom_range(0, 2500));
        endcase
    endfunction

    task automatic add_item(wsc_pkg::coord_t w, wsc_pkg::coord_t h, logic kx, logic ru,
                            wsc_pkg::coord_t lw, wsc_pkg::coord_t lh);
        resize_t r;
        r.w = w;
        r.h = h;
        r.kx = kx;
        r.ru = ru;
        r.lw = lw;
        r.lh = lh;
        resize_q.push_back(r);
    endtask

    task automatic random_config(int phase);
        int m;
        m = $urandom_range(0, 2);
        if (phase == 1)
        begin
            // extremes: everything at its largest
            write_reg(wsc_pkg::REG_MIN_SIZE, 32'h7FFF_FFFF);
            write_reg(wsc_pkg::REG_MAX_SIZE, 32'hFFFF_FFFF);
            write_reg(wsc_pkg::REG_BASE_SIZE, 32'h7FFF_FFFF);
            write_reg(wsc_pkg::REG_SIZE_STEP, 32'h7FFF_FFFF);
            write_reg(wsc_pkg::REG_RATIO_LO, 32'h7FFF_FFFF);
            write_reg(wsc_pkg::REG_RATIO_HI, 32'h7FFF_FFFF);
            write_reg(wsc_pkg::REG_ASPECT_ON, 32'h1);
            write_reg(wsc_pkg::REG_LIMIT_ON, 32'h1);
        end
        else if (phase == 2)
        begin
            // extremes: everything zero
            write_reg(wsc_pkg::REG_MIN_SIZE, 32'h0);
            write_reg(wsc_pkg::REG_MAX_SIZE, 32'h0);
            write_reg(wsc_pkg::REG_BASE_SIZE, 32'h0);
            write_reg(wsc_pkg::REG_SIZE_STEP, 32'h0);
            write_reg(wsc_pkg::REG_RATIO_LO, 32'h0);
            write_reg(wsc_pkg::REG_RATIO_HI, 32'h0);
            write_reg(wsc_pkg::REG_ASPECT_ON, 32'hFFFF_FFFE);
            write_reg(wsc_pkg::REG_LIMIT_ON, 32'h0);
        end
        else
        begin
            write_reg(wsc_pkg::REG_MIN_SIZE, pack_pair(rand_dim(m), rand_dim(m)));
            write_reg(wsc_pkg::REG_MAX_SIZE, pack_pair(rand_dim(m + 1) + 16'd200,
                                                       rand_dim(m + 1) + 16'd200));
            write_reg(wsc_pkg::REG_BASE_SIZE, pack_pair(rand_dim(0), rand_dim(0)));
            write_reg(wsc_pkg::REG_SIZE_STEP,
                      pack_pair(rand_dim($urandom_range(0, 1) ? 0 : 2),
                                rand_dim($urandom_range(0, 1) ? 0 : 2)));
            write_reg(wsc_pkg::REG_RATIO_LO,
                      pack_pair(rand_dim($urandom_range(0, 4) == 0 ? 2 : 0),
                                rand_dim(0)));
            write_reg(wsc_pkg::REG_RATIO_HI,
                      pack_pair(rand_dim(0),
                                rand_dim($urandom_range(0, 4) == 0 ? 2 : 0)));
            write_reg(wsc_pkg::REG_ASPECT_ON, 32'($urandom_range(0, 3) != 0));
            write_reg(wsc_pkg::REG_LIMIT_ON, $urandom);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.req_width = '0;
        req_if.req_height = '0;
        req_if.keep_x = 1'b0;
        req_if.round_up = 1'b0;
        req_if.limit_width = '0;
        req_if.limit_height = '0;
        res_if.ready = 1'b0;
        errors = 0;
        hold_ask = 0;
        idle_on = 1'b0;
        hint_regs[wsc_pkg::REG_MIN_SIZE] = 32'h0001_0001;
        hint_regs[wsc_pkg::REG_MAX_SIZE] = 32'h7FFF_7FFF;
        hint_regs[wsc_pkg::REG_BASE_SIZE] = 32'h0;
        hint_regs[wsc_pkg::REG_SIZE_STEP] = 32'h0001_0001;
        hint_regs[wsc_pkg::REG_RATIO_LO] = 32'h0001_0001;
        hint_regs[wsc_pkg::REG_RATIO_HI] = 32'h0001_0001;
        hint_regs[wsc_pkg::REG_ASPECT_ON] = 32'h0;
        hint_regs[wsc_pkg::REG_LIMIT_ON] = 32'h0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, field extremes
        add_item(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 16'sh7FFF, 16'sh7FFF);
        add_item(16'sh8000, 16'sh8000, 1'b1, 1'b1, 16'sh8000, 16'sh8000);
        add_item(16'sd0, 16'sd0, 1'b0, 1'b1, 16'sd0, 16'sd0);
        add_item(-16'sd1, 16'sd1, 1'b1, 1'b0, -16'sd1, 16'sd1);
        drain();

        // Directed: aspect repair both orders, zero term on max ratio,
        // step snapping with rounding, min above max, small/negative limits
        write_reg(wsc_pkg::REG_MIN_SIZE, {1'b0, 15'd50, 16'd40});
        write_reg(wsc_pkg::REG_MAX_SIZE, {1'b0, 15'd30, 16'd900});
        write_reg(wsc_pkg::REG_BASE_SIZE, {1'b0, 15'd3, 16'd5});
        write_reg(wsc_pkg::REG_SIZE_STEP, {1'b0, 15'd7, 16'd0});
        write_reg(wsc_pkg::REG_RATIO_LO, {1'b0, 15'd3, 16'd4});
        write_reg(wsc_pkg::REG_RATIO_HI, {1'b0, 15'd0, 16'd9});
        write_reg(wsc_pkg::REG_ASPECT_ON, 32'h1);
        write_reg(wsc_pkg::REG_LIMIT_ON, 32'h1);
        add_item(16'sd100, 16'sd400, 1'b1, 1'b0, 16'sd1000, 16'sd1000);
        add_item(16'sd100, 16'sd400, 1'b0, 1'b1, 16'sd1000, 16'sd1000);
        add_item(16'sd800, 16'sd10, 1'b1, 1'b1, 16'sd1000, 16'sd1000);
        add_item(16'sd500, 16'sd20, 1'b0, 1'b0, -16'sd5, 16'sd0);
        add_item(16'sd500, 16'sd20, 1'b0, 1'b0, 16'sd3, 16'sd1);
        drain();
        write_reg(wsc_pkg::REG_MAX_SIZE, {1'b0, 15'd700, 16'd900});
        write_reg(wsc_pkg::REG_MIN_SIZE, {1'b0, 15'd1, 16'd1});
        write_reg(wsc_pkg::REG_RATIO_LO, {1'b0, 15'd0, 16'd4});
        write_reg(wsc_pkg::REG_RATIO_HI, {1'b0, 15'd2, 16'd5});
        add_item(16'sd600, 16'sd50, 1'b1, 1'b0, 16'sh7FFF, 16'sh7FFF);
        add_item(16'sd600, 16'sd50, 1'b0, 1'b1, 16'sh7FFF, 16'sh7FFF);
        add_item(16'sd10, 16'sd600, 1'b1, 1'b1, 16'sh7FFF, 16'sh7FFF);
        add_item(16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 16'sh8000, 16'sh7FFF);
        drain();

        // Random phases: new settings each phase, idling on in most
        for (int ph = 1; ph <= 16; ph++)
        begin
            random_config(ph);
            idle_on = (ph % 4) != 0;
            if (ph == 5 || ph == 12)
            begin
                hold_ask++;
            end
            for (int n = 0; n < 95; n++)
            begin
                add_item(rand_coord(), rand_coord(), 1'($urandom), 1'($urandom),
                         $urandom_range(0, 3) == 0
                             ? wsc_pkg::coord_t'($urandom)
                             : wsc_pkg::coord_t'($urandom_range(0, 3000)),
                         $urandom_range(0, 3) == 0
                             ? wsc_pkg::coord_t'($urandom)
                             : wsc_pkg::coord_t'($urandom_range(0, 3000)));
            end
            drain();
        end

        repeat (250) @(posedge clk);
        if (errors == 0 && fitted_q.size() == 0)
        begin
            $display("window_size_constrainer_top verification clean");
        end
        else
        begin
            if (fitted_q.size() != 0)
            begin
                $display("%0t: %0d expected results never arrived", $time, fitted_q.size());
            end
            $display("window_size_constrainer_top verification failed");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("window_size_constrainer_top verification failed");
        $finish;
    end

endmodule

// ===== window_size_constrainer_top.f =====
+incdir+sv
sv/wsc_pkg.sv
sv/wsc_if.sv
sv/wsc_div_pipe.sv
sv/wsc_ratio_fix.sv
sv/wsc_snap.sv
sv/window_size_constrainer_top.sv
dv/tb_top.sv
